FILE: rtl/phpn_pkg.sv
`timescale 1ns / 1ps

package phpn_pkg;

  localparam int BINS       = 256;
  localparam int COUNT_BITS = 22;
  localparam int FRAC_BITS  = 16;

  localparam int CMD_W = 2;
  localparam int PIX_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

endpackage

FILE: rtl/phpn_ifs.sv
`timescale 1ns / 1ps

interface phpn_in_if;
  logic                        valid;
  logic                        ready;
  logic [phpn_pkg::CMD_W-1:0]  cmd;
  logic [phpn_pkg::PIX_W-1:0]  pixel;
  logic [phpn_pkg::PIX_W-1:0]  bin;

  modport source (output valid, cmd, pixel, bin, input ready);
  modport sink   (input valid, cmd, pixel, bin, output ready);
endinterface

interface phpn_out_if #(
  parameter int COUNT_BITS = phpn_pkg::COUNT_BITS,
  parameter int FRAC_BITS  = phpn_pkg::FRAC_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] bin_count;
  logic [FRAC_BITS:0]    scaled;
  logic                  empty_res;

  modport source (output valid, bin_count, scaled, empty_res, input ready);
  modport sink   (input valid, bin_count, scaled, empty_res, output ready);
endinterface

FILE: rtl/pixel_histogram_peak_normalized.sv
`timescale 1ns / 1ps

// 256-bin pixel histogram with running peak and peak-normalized readout.
// in_chan carries transactions with cmd add (count pixel), read (query bin)
// or clear (zero all bins and the peak); out_chan carries one result per
// read: the raw saturated count, count/peak with FRAC_BITS fraction bits
// (2^FRAC_BITS is one) and an empty flag when the peak is zero.
// Add and clear transactions are taken one per cycle while no read is in
// flight: the bin memory does a read-modify-write with a registered read,
// and a count written back is forwarded to a transaction that reads the
// same bin next cycle. A read passes through the memory read register, the
// restoring divider (FRAC_BITS + 1 quotient bits, one quotient bit per
// cycle) and the output register; with a zero peak the divider is skipped.
// in_chan.ready stays low from a read until its result is loaded.
// While out_chan is stalled, adds and clears keep flowing up to the next
// read, which waits in the divider and holds in_chan until the output
// register is free.
// Reset (rst_n low, synchronous) empties the histogram at once through
// per-bin valid bits; a clear transaction does the same.

module pixel_histogram_peak_normalized #(
  parameter int BINS       = phpn_pkg::BINS,
  parameter int COUNT_BITS = phpn_pkg::COUNT_BITS,
  parameter int FRAC_BITS  = phpn_pkg::FRAC_BITS
) (
  input  logic    clk,
  input  logic    rst_n,
  phpn_in_if.sink in_chan,
  phpn_out_if.source out_chan
);

  localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int STEP_W = $clog2(FRAC_BITS + 2);
  localparam logic [phpn_pkg::PIX_W:0] BIN_LIM = (phpn_pkg::PIX_W + 1)'(BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // bin memory and per-bin valid bits
  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rdata_r;
  logic [BINS-1:0]       valid_r;
  logic                  rd_valid_r;

  // stage 1: item whose memory read is in flight
  logic             s1_add_r;
  logic             s1_read_r;
  logic             s1_oob_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic             fwd_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [COUNT_BITS-1:0] peak_r;

  // divider
  logic                  div_busy_r;
  logic [STEP_W-1:0]     div_cnt_r;
  logic [COUNT_BITS:0]   rem_r;
  logic [COUNT_BITS-1:0] dvs_r;
  logic [FRAC_BITS:0]    quo_r;
  logic [COUNT_BITS-1:0] div_count_r;
  logic                  div_empty_r;

  // output register
  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic [FRAC_BITS:0]    out_scaled_r;
  logic                  out_empty_r;

  logic                  accept;
  logic                  is_add, is_read, is_clear;
  logic                  pix_in, bin_in;
  logic [IDX_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  wr_en;
  logic                  fwd_nxt;
  logic                  div_done;
  logic                  out_load;
  logic                  ge;
  logic [COUNT_BITS:0]   rem_sub;
  logic [COUNT_BITS:0]   rem_nxt;
  logic [FRAC_BITS:0]    quo_nxt;

  assign in_chan.ready = !s1_read_r && !div_busy_r;
  assign accept        = in_chan.valid && in_chan.ready;

  assign pix_in   = {1'b0, in_chan.pixel} < BIN_LIM;
  assign bin_in   = {1'b0, in_chan.bin} < BIN_LIM;
  assign is_add   = (in_chan.cmd == phpn_pkg::CMD_ADD) && pix_in;
  assign is_read  = in_chan.cmd == phpn_pkg::CMD_READ;
  assign is_clear = in_chan.cmd == phpn_pkg::CMD_CLEAR;

  always_comb begin
    if (is_read) begin
      rd_addr = in_chan.bin[IDX_W-1:0];
    end else begin
      rd_addr = in_chan.pixel[IDX_W-1:0];
    end
  end

  // count of the stage 1 bin, taking the previous cycle's write into account
  always_comb begin
    if (fwd_r) begin
      cur_count = fwd_data_r;
    end else if (rd_valid_r) begin
      cur_count = rdata_r;
    end else begin
      cur_count = '0;
    end
  end

  assign cnt_nxt = (cur_count == CNT_MAX) ? cur_count : cur_count + 1'b1;
  assign wr_en   = s1_add_r;
  assign fwd_nxt = accept && (is_add || is_read) && s1_add_r && (rd_addr == s1_addr_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= cnt_nxt;
    end
    if (accept) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (accept && is_clear) begin
      // clear wins over the write-back of an add still in stage 1
      valid_r <= '0;
      peak_r  <= '0;
    end else if (wr_en) begin
      valid_r[s1_addr_r] <= 1'b1;
      if (cnt_nxt > peak_r) begin
        peak_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_add_r  <= 1'b0;
      s1_read_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      s1_add_r  <= accept && is_add;
      s1_read_r <= accept && is_read;
      fwd_r     <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= rd_addr;
      s1_oob_r   <= is_read && !bin_in;
      rd_valid_r <= valid_r[rd_addr];
      fwd_data_r <= cnt_nxt;
    end
  end

  // restoring division, one quotient bit per cycle; rem stays below 2*divisor
  assign ge      = rem_r >= {1'b0, dvs_r};
  assign rem_sub = ge ? rem_r - {1'b0, dvs_r} : rem_r;
  assign rem_nxt = {rem_sub[COUNT_BITS-1:0], 1'b0};
  assign quo_nxt = {quo_r[FRAC_BITS-1:0], ge};

  assign div_done = div_busy_r && (div_cnt_r == '0);
  assign out_load = div_done && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (s1_read_r) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= (peak_r == '0) ? '0 : STEP_W'(FRAC_BITS + 1);
    end else if (div_busy_r && (div_cnt_r != '0)) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end else if (out_load) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_read_r) begin
      div_count_r <= s1_oob_r ? '0 : cur_count;
      rem_r       <= {1'b0, (s1_oob_r ? {COUNT_BITS{1'b0}} : cur_count)};
      dvs_r       <= peak_r;
      div_empty_r <= peak_r == '0;
      quo_r       <= '0;
    end else if (div_busy_r && (div_cnt_r != '0)) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r  <= div_count_r;
      out_scaled_r <= div_empty_r ? '0 : quo_r;
      out_empty_r  <= div_empty_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.bin_count = out_count_r;
  assign out_chan.scaled    = out_scaled_r;
  assign out_chan.empty_res = out_empty_r;

endmodule

FILE: tb/phpn_readout_checker.sv
`timescale 1ns / 1ps

module phpn_readout_checker #(
  parameter int BINS       = phpn_pkg::BINS,
  parameter int COUNT_BITS = phpn_pkg::COUNT_BITS,
  parameter int FRAC_BITS  = phpn_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  phpn_in_if   in_mon,
  phpn_out_if  out_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic [FRAC_BITS:0]    scaled;
    logic                  empty_res;
  } readout_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] hist_bins [BINS];
  logic [COUNT_BITS-1:0] hist_peak;
  readout_t              readout_q [$];
  readout_t              want;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t ns mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  // histogram model: one accepted input transaction, read results queued
  task automatic update_histogram(logic [phpn_pkg::CMD_W-1:0] cmd,
                                  logic [phpn_pkg::PIX_W-1:0] px,
                                  logic [phpn_pkg::PIX_W-1:0] bn);
    logic [COUNT_BITS-1:0] c;
    logic [63:0]           num;
    logic [63:0]           quo;
    readout_t              r;
    case (cmd)
      phpn_pkg::CMD_ADD: begin
        if (int'(px) < BINS) begin
          c = hist_bins[px];
          if (c != COUNT_MAX) c = c + 1'b1;
          hist_bins[px] = c;
          if (c > hist_peak) hist_peak = c;
        end
      end
      phpn_pkg::CMD_READ: begin
        c = (int'(bn) < BINS) ? hist_bins[bn] : '0;
        r.bin_count = c;
        r.empty_res = (hist_peak == '0);
        if (r.empty_res) begin
          r.scaled = '0;
        end else begin
          num = 64'(c) << FRAC_BITS;
          quo = num / 64'(hist_peak);
          r.scaled = quo[FRAC_BITS:0];
        end
        readout_q.push_back(r);
        outstanding++;
      end
      phpn_pkg::CMD_CLEAR: begin
        for (int i = 0; i < BINS; i++) hist_bins[i] = '0;
        hist_peak = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BINS; i++) hist_bins[i] = '0;
      hist_peak = '0;
      readout_q.delete();
      outstanding = 0;
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        update_histogram(in_mon.cmd, in_mon.pixel, in_mon.bin);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (readout_q.size() == 0) begin
          report_mismatch("result with no read outstanding, bin_count",
                          64'(out_mon.bin_count), 64'(0));
        end else begin
          want = readout_q.pop_front();
          outstanding--;
          if (out_mon.bin_count !== want.bin_count) begin
            report_mismatch("bin_count", 64'(out_mon.bin_count), 64'(want.bin_count));
          end
          if (out_mon.scaled !== want.scaled) begin
            report_mismatch("scaled", 64'(out_mon.scaled), 64'(want.scaled));
          end
          if (out_mon.empty_res !== want.empty_res) begin
            report_mismatch("empty_res", 64'(out_mon.empty_res), 64'(want.empty_res));
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_pixel_histogram_peak_normalized.sv
`timescale 1ns / 1ps

module tb_pixel_histogram_peak_normalized;

  localparam logic [phpn_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [phpn_pkg::PIX_W-1:0] RUN_BIN    = 8'd200;

  localparam int IDLE_PCT     = 32;
  localparam int RUN_ADDS     = 64;
  localparam int RANDOM_ITEMS = 1760;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * (phpn_pkg::FRAC_BITS + 3);
  localparam int LIMIT_CYCLES = 500000;

  logic clk;
  logic rst_n;
  bit   src_idle_on;
  int   cycle_count;
  int   fail_count;
  int   outstanding;

  phpn_in_if in_ch ();
  phpn_out_if #(
    .COUNT_BITS(phpn_pkg::COUNT_BITS),
    .FRAC_BITS (phpn_pkg::FRAC_BITS)
  ) out_ch ();

  pixel_histogram_peak_normalized #(
    .BINS      (phpn_pkg::BINS),
    .COUNT_BITS(phpn_pkg::COUNT_BITS),
    .FRAC_BITS (phpn_pkg::FRAC_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  phpn_readout_checker #(
    .BINS      (phpn_pkg::BINS),
    .COUNT_BITS(phpn_pkg::COUNT_BITS),
    .FRAC_BITS (phpn_pkg::FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL pixel_histogram_peak_normalized");
      $finish;
    end
  end

  function automatic logic [phpn_pkg::PIX_W-1:0] rnd8();
    return phpn_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  // offer one transaction and hold it until the block takes it
  task automatic send_item(logic [phpn_pkg::CMD_W-1:0] cmd,
                           logic [phpn_pkg::PIX_W-1:0] px,
                           logic [phpn_pkg::PIX_W-1:0] bn);
    while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.pixel <= px;
    in_ch.bin   <= bn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // result side: random stalls, two long hold-offs, one stretch always ready
  initial begin
    int seen;
    int hold_left;
    int holds_done;
    seen       = 0;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) seen++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_done < 2 && seen >= 150 + holds_done * 150) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        out_ch.ready <= 1'b0;
      end else if (seen >= 400 && seen < 600) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int                           r;
    logic [phpn_pkg::PIX_W-1:0]   px;
    logic [phpn_pkg::PIX_W-1:0]   bn;
    logic [phpn_pkg::PIX_W-1:0]   hot_base;
    logic [phpn_pkg::CMD_W-1:0]   cmd_sel;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= phpn_pkg::CMD_ADD;
    in_ch.pixel <= '0;
    in_ch.bin   <= '0;
    src_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty histogram, edge bins, peak bin, zero bin, unused command
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd0);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd255);
    send_item(phpn_pkg::CMD_ADD, 8'd0, rnd8());
    send_item(phpn_pkg::CMD_ADD, 8'd255, rnd8());
    send_item(phpn_pkg::CMD_ADD, 8'd255, rnd8());
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd255);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd0);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd7);
    send_item(CMD_UNUSED, 8'd255, 8'd255);
    send_item(phpn_pkg::CMD_ADD, 8'h55, 8'hAA);
    send_item(phpn_pkg::CMD_ADD, 8'hAA, 8'h55);
    send_item(phpn_pkg::CMD_READ, 8'h55, 8'hAA);
    send_item(phpn_pkg::CMD_CLEAR, 8'd255, 8'd255);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd255);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd0);
    // one third of the peak truncates
    send_item(phpn_pkg::CMD_ADD, 8'd1, rnd8());
    send_item(phpn_pkg::CMD_ADD, 8'd1, rnd8());
    send_item(phpn_pkg::CMD_ADD, 8'd1, rnd8());
    send_item(phpn_pkg::CMD_ADD, 8'd2, rnd8());
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd2);
    send_item(phpn_pkg::CMD_READ, rnd8(), 8'd1);
    send_item(CMD_UNUSED, 8'd0, 8'd0);
    send_item(phpn_pkg::CMD_CLEAR, 8'd0, 8'd0);

    // back-to-back adds to one bin, each count forwarded to the next add
    src_idle_on = 1'b0;
    for (int i = 0; i < RUN_ADDS; i++) begin
      send_item(phpn_pkg::CMD_ADD, RUN_BIN, rnd8());
    end
    src_idle_on = 1'b1;
    send_item(phpn_pkg::CMD_READ, rnd8(), RUN_BIN);
    send_item(phpn_pkg::CMD_ADD, RUN_BIN + 8'd1, rnd8());
    send_item(phpn_pkg::CMD_READ, rnd8(), RUN_BIN + 8'd1);
    send_item(phpn_pkg::CMD_READ, rnd8(), RUN_BIN);
    send_item(phpn_pkg::CMD_CLEAR, rnd8(), rnd8());
    send_item(phpn_pkg::CMD_READ, rnd8(), RUN_BIN);

    // random mix, half the pixels and reads aimed at a small hot range
    hot_base = rnd8();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      src_idle_on = !(i >= 700 && i < 1000);
      r  = int'($urandom_range(0, 99));
      px = $urandom_range(0, 1) ?
           hot_base + phpn_pkg::PIX_W'($urandom_range(0, 7)) : rnd8();
      bn = $urandom_range(0, 1) ?
           hot_base + phpn_pkg::PIX_W'($urandom_range(0, 7)) : rnd8();
      if (r < 60) begin
        cmd_sel = phpn_pkg::CMD_ADD;
      end else if (r < 93) begin
        cmd_sel = phpn_pkg::CMD_READ;
      end else if (r < 95) begin
        cmd_sel = phpn_pkg::CMD_CLEAR;
        hot_base = rnd8();
      end else begin
        cmd_sel = CMD_UNUSED;
      end
      send_item(cmd_sel, px, bn);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS pixel_histogram_peak_normalized");
    end else begin
      $display("FAIL pixel_histogram_peak_normalized");
    end
    $finish;
  end

endmodule

FILE: pixel_histogram_peak_normalized.f
rtl/phpn_pkg.sv
rtl/phpn_ifs.sv
rtl/pixel_histogram_peak_normalized.sv
tb/phpn_readout_checker.sv
tb/tb_pixel_histogram_peak_normalized.sv
